FILE: hw/rtl/gss_pkg.sv
// ----------------------------------------------------------------------------
// gss_pkg
// Types, constants and saturating helpers for the Grad-Shafranov SOR point
// update: payload structs, register indexes, reset values, 64-bit arithmetic.
// ----------------------------------------------------------------------------
package gss_pkg;

   localparam int VALUE_WIDTH      = 32;
   localparam int ACC_WIDTH        = 64;
   localparam int INV_RADIUS_WIDTH = 32;
   localparam int CHANGE_WIDTH     = 31;

   localparam int RELAX_WIDTH    = 18;
   localparam int COEF_WIDTH     = 32;
   localparam int INV_DIAG_WIDTH = 48;

   localparam int RELAX_FRAC      = 16;
   localparam int COEF_FRAC       = 16;
   localparam int INV_RADIUS_FRAC = 28;
   localparam int INV_DIAG_FRAC   = 48;

   localparam int SUM_SCALE_SHIFT  = 4;
   localparam int DIFF_SCALE_SHIFT = 3;

   localparam int MUL_LATENCY = 4;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 48;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_RELAX_FACTOR  = 3'd0,
      CSR_COEF_R_SECOND = 3'd1,
      CSR_COEF_Z_SECOND = 3'd2,
      CSR_COEF_R_FIRST  = 3'd3,
      CSR_INV_DIAG_MAG  = 3'd4
   } csr_index_type;

   localparam logic [RELAX_WIDTH-1:0]    RELAX_RESET         = 18'd98304;
   localparam logic [COEF_WIDTH-1:0]     COEF_R_SECOND_RESET = 32'd194854912;
   localparam logic [COEF_WIDTH-1:0]     COEF_Z_SECOND_RESET = 32'd195619717;
   localparam logic [COEF_WIDTH-1:0]     COEF_R_FIRST_RESET  = 32'd1031582;
   localparam logic [INV_DIAG_WIDTH-1:0] INV_DIAG_RESET      = 48'd1574700000;

   typedef logic signed [ACC_WIDTH-1:0]   acc_type;
   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   localparam acc_type ACC_MAX   = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam acc_type ACC_MIN   = {1'b1, {(ACC_WIDTH-1){1'b0}}};
   localparam acc_type VALUE_MAX = ACC_WIDTH'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
   localparam acc_type VALUE_MIN = ~VALUE_MAX;

   typedef struct packed {
      value_type                   center;
      value_type                   r_plus_one;
      value_type                   r_plus_two;
      value_type                   r_minus_one;
      value_type                   r_minus_two;
      value_type                   z_plus_one;
      value_type                   z_plus_two;
      value_type                   z_minus_one;
      value_type                   z_minus_two;
      logic [INV_RADIUS_WIDTH-1:0] inv_radius;
      value_type                   source_term;
   } req_type;

   typedef struct packed {
      value_type               relaxed_value;
      logic [CHANGE_WIDTH-1:0] abs_change;
   } rsp_type;

   function automatic acc_type widen(value_type v);
      return ACC_WIDTH'(v);
   endfunction

   function automatic acc_type sat_add(acc_type a, acc_type b);
      logic [ACC_WIDTH:0] s;
      s = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
      if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
         return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
      end
      return s[ACC_WIDTH-1:0];
   endfunction

   function automatic acc_type sat_neg(acc_type a);
      return (a == ACC_MIN) ? ACC_MAX : -a;
   endfunction

   function automatic acc_type sat_sub(acc_type a, acc_type b);
      return sat_add(a, sat_neg(b));
   endfunction

   // multiply by a power of two, clipped to the accumulator range
   function automatic acc_type sat_scale(acc_type a, int sh);
      if (a > (ACC_MAX >>> sh)) begin
         return ACC_MAX;
      end
      if (a < (ACC_MIN >>> sh)) begin
         return ACC_MIN;
      end
      return a <<< sh;
   endfunction

endpackage

FILE: hw/rtl/grad_shafranov_sor_point_update.sv
// ----------------------------------------------------------------------------
// grad_shafranov_sor_point_update
// One relaxed update of the Grad-Shafranov operator at a grid point from a
// fourth-order five-point stencil in R and Z; gives new value and |change|.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | beat
//   --------+----------------------+-----------------------------------
//   req     | req_valid/req_stall  | req_data: stencil, 1/r, source
//   rsp     | rsp_valid/rsp_stall  | rsp_data: relaxed value, |change|
//   csr     | csr_write            | csr_index, csr_data
//
// One beat per cycle in and out while req_stall is low. The path runs through
// four 4-stage multiply units in series (stencil terms, 1/r, inverse diagonal,
// relaxation) plus combine stages.
// Reset is synchronous: valids clear, configuration registers load their defaults.
// A stalled result parks in a skid register; req_stall is high while it is full.
//
module grad_shafranov_sor_point_update (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  gss_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output gss_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_write,
   input  logic [gss_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [gss_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import gss_pkg::*;

   localparam int STG_STENCIL  = 2;
   localparam int STG_TERMS    = STG_STENCIL + MUL_LATENCY;
   localparam int STG_DERIV    = STG_TERMS + MUL_LATENCY;
   localparam int STG_NUM      = STG_DERIV + 1;
   localparam int STG_EST      = STG_NUM + MUL_LATENCY;
   localparam int STG_DIFF     = STG_EST + 1;
   localparam int STG_STEP     = STG_DIFF + MUL_LATENCY;
   localparam int STG_NEW      = STG_STEP + 1;
   localparam int STG_LAST     = STG_NEW + 1;
   localparam int NUM_STAGES   = STG_LAST + 1;
   localparam int CENTER_DEPTH = STG_NEW;
   localparam int SIDE_DEPTH   = STG_TERMS;
   localparam int PART_DEPTH   = MUL_LATENCY - 1;

   logic                          advance;
   logic [NUM_STAGES-1:0]         vld_ff;
   logic [NUM_STAGES-1:0]         vld_in;

   logic [RELAX_WIDTH-1:0]        relax_ff;
   logic [COEF_WIDTH-1:0]         coef_r2_ff;
   logic [COEF_WIDTH-1:0]         coef_z2_ff;
   logic [COEF_WIDTH-1:0]         coef_r1_ff;
   logic [INV_DIAG_WIDTH-1:0]     inv_diag_ff;

   req_type                       req_ff;
   acc_type                       sum_r1_ff;
   acc_type                       sum_r2_ff;
   acc_type                       sum_z1_ff;
   acc_type                       sum_z2_ff;
   acc_type                       dif_r1_ff;
   acc_type                       dif_r2_ff;
   acc_type                       sr_ff;
   acc_type                       sz_ff;
   acc_type                       d_ff;
   value_type                     center_ff [CENTER_DEPTH];
   value_type                     source_ff [SIDE_DEPTH];
   logic [INV_RADIUS_WIDTH-1:0]   inv_r_ff [SIDE_DEPTH];

   acc_type                       tr;
   acc_type                       tz;
   acc_type                       dc;
   acc_type                       dr;
   acc_type                       quot;
   acc_type                       step;

   acc_type                       n1_ff;
   acc_type                       tz_hold_ff;
   acc_type                       part_ff [PART_DEPTH];
   acc_type                       num_ff;
   acc_type                       diff_ff;
   acc_type                       new_sum;
   acc_type                       new_clamp;
   value_type                     new_ff;
   acc_type                       change_full;
   acc_type                       change_abs;
   value_type                     relaxed_ff;
   logic [CHANGE_WIDTH-1:0]       change_ff;

   rsp_type                       pipe_out;
   logic                          rsp_take;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   rsp_type                       rsp_data_ff;
   rsp_type                       rsp_data_in;
   logic                          skid_valid_ff;
   logic                          skid_valid_in;
   rsp_type                       skid_data_ff;
   rsp_type                       skid_data_in;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         relax_ff    <= RELAX_RESET;
         coef_r2_ff  <= COEF_R_SECOND_RESET;
         coef_z2_ff  <= COEF_Z_SECOND_RESET;
         coef_r1_ff  <= COEF_R_FIRST_RESET;
         inv_diag_ff <= INV_DIAG_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RELAX_FACTOR:  relax_ff    <= csr_data[RELAX_WIDTH-1:0];
            CSR_COEF_R_SECOND: coef_r2_ff  <= csr_data[COEF_WIDTH-1:0];
            CSR_COEF_Z_SECOND: coef_z2_ff  <= csr_data[COEF_WIDTH-1:0];
            CSR_COEF_R_FIRST:  coef_r1_ff  <= csr_data[COEF_WIDTH-1:0];
            CSR_INV_DIAG_MAG:  inv_diag_ff <= csr_data[INV_DIAG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign vld_in    = {vld_ff[NUM_STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // stencil sums, terms and combine
   always_ff @(posedge clock) begin
      if (advance) begin
         req_ff <= req_data;

         sum_r1_ff <= sat_add(widen(req_ff.r_plus_one), widen(req_ff.r_minus_one));
         sum_r2_ff <= sat_add(widen(req_ff.r_plus_two), widen(req_ff.r_minus_two));
         sum_z1_ff <= sat_add(widen(req_ff.z_plus_one), widen(req_ff.z_minus_one));
         sum_z2_ff <= sat_add(widen(req_ff.z_plus_two), widen(req_ff.z_minus_two));
         dif_r1_ff <= sat_sub(widen(req_ff.r_plus_one), widen(req_ff.r_minus_one));
         dif_r2_ff <= sat_sub(widen(req_ff.r_plus_two), widen(req_ff.r_minus_two));

         sr_ff <= sat_sub(sat_scale(sum_r1_ff, SUM_SCALE_SHIFT), sum_r2_ff);
         sz_ff <= sat_sub(sat_scale(sum_z1_ff, SUM_SCALE_SHIFT), sum_z2_ff);
         d_ff  <= sat_sub(sat_scale(dif_r1_ff, DIFF_SCALE_SHIFT), dif_r2_ff);

         center_ff[0] <= req_ff.center;
         for (int k = 1; k < CENTER_DEPTH; k++) begin
            center_ff[k] <= center_ff[k-1];
         end
         source_ff[0] <= req_ff.source_term;
         inv_r_ff[0]  <= req_ff.inv_radius;
         for (int k = 1; k < SIDE_DEPTH; k++) begin
            source_ff[k] <= source_ff[k-1];
            inv_r_ff[k]  <= inv_r_ff[k-1];
         end

         n1_ff      <= sat_sub(widen(source_ff[SIDE_DEPTH-1]), tr);
         tz_hold_ff <= tz;
         part_ff[0] <= sat_sub(n1_ff, tz_hold_ff);
         for (int k = 1; k < PART_DEPTH; k++) begin
            part_ff[k] <= part_ff[k-1];
         end
         num_ff <= sat_add(part_ff[PART_DEPTH-1], dr);

         diff_ff <= sat_sub(sat_neg(quot), widen(center_ff[STG_EST-1]));

         new_ff     <= new_clamp[VALUE_WIDTH-1:0];
         relaxed_ff <= new_ff;
         change_ff  <= change_abs[CHANGE_WIDTH-1:0];
      end
   end

   gss_mul_shift #(.B_WIDTH(COEF_WIDTH), .SHIFT(COEF_FRAC)) u_mul_tr (
      .clock(clock), .advance(advance), .a(sr_ff), .b(coef_r2_ff), .p(tr)
   );

   gss_mul_shift #(.B_WIDTH(COEF_WIDTH), .SHIFT(COEF_FRAC)) u_mul_tz (
      .clock(clock), .advance(advance), .a(sz_ff), .b(coef_z2_ff), .p(tz)
   );

   gss_mul_shift #(.B_WIDTH(COEF_WIDTH), .SHIFT(COEF_FRAC)) u_mul_dc (
      .clock(clock), .advance(advance), .a(d_ff), .b(coef_r1_ff), .p(dc)
   );

   gss_mul_shift #(.B_WIDTH(INV_RADIUS_WIDTH), .SHIFT(INV_RADIUS_FRAC)) u_mul_dr (
      .clock(clock), .advance(advance), .a(dc), .b(inv_r_ff[SIDE_DEPTH-1]), .p(dr)
   );

   gss_mul_shift #(.B_WIDTH(INV_DIAG_WIDTH), .SHIFT(INV_DIAG_FRAC)) u_mul_est (
      .clock(clock), .advance(advance), .a(num_ff), .b(inv_diag_ff), .p(quot)
   );

   gss_mul_shift #(.B_WIDTH(RELAX_WIDTH), .SHIFT(RELAX_FRAC)) u_mul_step (
      .clock(clock), .advance(advance), .a(diff_ff), .b(relax_ff), .p(step)
   );

   always_comb begin
      new_sum = sat_add(widen(center_ff[STG_STEP-1]), step);
      if (new_sum > VALUE_MAX) begin
         new_clamp = VALUE_MAX;
      end else if (new_sum < VALUE_MIN) begin
         new_clamp = VALUE_MIN;
      end else begin
         new_clamp = new_sum;
      end
   end

   always_comb begin
      change_full = sat_sub(widen(new_ff), widen(center_ff[STG_NEW-1]));
      change_abs  = (change_full < 0) ? sat_neg(change_full) : change_full;
      if (change_abs > VALUE_MAX) begin
         change_abs = VALUE_MAX;
      end
   end

   assign pipe_out.relaxed_value = relaxed_ff;
   assign pipe_out.abs_change    = change_ff;

   // output register and skid
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      rsp_take      = rsp_valid_ff && !rsp_stall;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!rsp_valid_ff || rsp_take) begin
         rsp_valid_in = vld_ff[STG_LAST];
         rsp_data_in  = pipe_out;
      end else if (vld_ff[STG_LAST]) begin
         skid_valid_in = 1'b1;
         skid_data_in  = pipe_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hw/rtl/gss_mul_shift.sv
// ----------------------------------------------------------------------------
// gss_mul_shift
// Four-stage signed-by-unsigned multiply, rounded on the magnitude and
// shifted right by a fixed count, saturated to the accumulator range.
// ----------------------------------------------------------------------------
module gss_mul_shift #(
   parameter int B_WIDTH = gss_pkg::COEF_WIDTH,
   parameter int SHIFT   = gss_pkg::COEF_FRAC
) (
   input  logic                 clock,
   input  logic                 advance,
   input  gss_pkg::acc_type     a,
   input  logic [B_WIDTH-1:0]   b,
   output gss_pkg::acc_type     p
);
   import gss_pkg::*;

   localparam int HALF          = ACC_WIDTH / 2;
   localparam int B_CHUNKS      = (B_WIDTH + HALF - 1) / HALF;
   localparam int B_PAD         = B_CHUNKS * HALF;
   localparam int PROD_WIDTH    = ACC_WIDTH + B_PAD;
   localparam int SHIFTED_WIDTH = PROD_WIDTH + 1 - SHIFT;

   logic                    neg1_ff;
   logic                    neg2_ff;
   logic                    neg3_ff;
   logic [ACC_WIDTH-1:0]    mag_ff;
   logic [B_PAD-1:0]        b_ff;
   logic [ACC_WIDTH-1:0]    pp_lo_ff [B_CHUNKS];
   logic [ACC_WIDTH-1:0]    pp_hi_ff [B_CHUNKS];
   logic [PROD_WIDTH-1:0]   prod_sum;
   logic [PROD_WIDTH-1:0]   prod_ff;
   logic [PROD_WIDTH:0]     rounded;
   logic [SHIFTED_WIDTH-1:0] shifted;
   logic [ACC_WIDTH-1:0]    mag_out;
   acc_type                 result;
   acc_type                 p_ff;

   always_comb begin
      prod_sum = '0;
      for (int k = 0; k < B_CHUNKS; k++) begin
         prod_sum = prod_sum + (PROD_WIDTH'(pp_lo_ff[k]) << (HALF * k))
                             + (PROD_WIDTH'(pp_hi_ff[k]) << (HALF * (k + 1)));
      end
   end

   always_comb begin
      rounded = {1'b0, prod_ff} + ((PROD_WIDTH + 1)'(1) << (SHIFT - 1));
      shifted = rounded[PROD_WIDTH:SHIFT];
      mag_out = shifted[ACC_WIDTH-1:0];
      if (|shifted[SHIFTED_WIDTH-1:ACC_WIDTH-1]) begin
         result = neg3_ff ? ACC_MIN : ACC_MAX;
      end else begin
         result = neg3_ff ? -mag_out : mag_out;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         neg1_ff <= a[ACC_WIDTH-1];
         mag_ff  <= a[ACC_WIDTH-1] ? -a : a;
         b_ff    <= B_PAD'(b);
         neg2_ff <= neg1_ff;
         for (int k = 0; k < B_CHUNKS; k++) begin
            pp_lo_ff[k] <= mag_ff[HALF-1:0] * b_ff[k*HALF +: HALF];
            pp_hi_ff[k] <= mag_ff[ACC_WIDTH-1:HALF] * b_ff[k*HALF +: HALF];
         end
         neg3_ff <= neg2_ff;
         prod_ff <= prod_sum;
         p_ff    <= result;
      end
   end

   assign p = p_ff;

endmodule
